// ----- src/kdes_pkg.sv -----
`timescale 1ns / 1ps

package kdes_pkg;

  localparam int unsigned BlockW = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned SelW   = 6;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [HalfW-1:0]  half_t;
  typedef logic [SelW-1:0]   sel_t;

  // des bit numbers, 1-based, first bit is the msb of the block
  localparam logic [7:0] PermIp [64] = '{
    8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18, 8'd10, 8'd2,
    8'd60, 8'd52, 8'd44, 8'd36, 8'd28, 8'd20, 8'd12, 8'd4,
    8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,
    8'd64, 8'd56, 8'd48, 8'd40, 8'd32, 8'd24, 8'd16, 8'd8,
    8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,
    8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
    8'd61, 8'd53, 8'd45, 8'd37, 8'd29, 8'd21, 8'd13, 8'd5,
    8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7
  };

  localparam logic [7:0] PermFp [64] = '{
    8'd40, 8'd8,  8'd48, 8'd16, 8'd56, 8'd24, 8'd64, 8'd32,
    8'd39, 8'd7,  8'd47, 8'd15, 8'd55, 8'd23, 8'd63, 8'd31,
    8'd38, 8'd6,  8'd46, 8'd14, 8'd54, 8'd22, 8'd62, 8'd30,
    8'd37, 8'd5,  8'd45, 8'd13, 8'd53, 8'd21, 8'd61, 8'd29,
    8'd36, 8'd4,  8'd44, 8'd12, 8'd52, 8'd20, 8'd60, 8'd28,
    8'd35, 8'd3,  8'd43, 8'd11, 8'd51, 8'd19, 8'd59, 8'd27,
    8'd34, 8'd2,  8'd42, 8'd10, 8'd50, 8'd18, 8'd58, 8'd26,
    8'd33, 8'd1,  8'd41, 8'd9,  8'd49, 8'd17, 8'd57, 8'd25
  };

  localparam logic [7:0] PermP [32] = '{
    8'd16, 8'd7,  8'd20, 8'd21, 8'd29, 8'd12, 8'd28, 8'd17,
    8'd1,  8'd15, 8'd23, 8'd26, 8'd5,  8'd18, 8'd31, 8'd10,
    8'd2,  8'd8,  8'd24, 8'd14, 8'd32, 8'd27, 8'd3,  8'd9,
    8'd19, 8'd13, 8'd30, 8'd6,  8'd22, 8'd11, 8'd4,  8'd25
  };

  // paired s-boxes: high nibble even box, low nibble odd box
  localparam logic [7:0] SboxPair [4][64] = '{
    '{
      8'hef, 8'h03, 8'h41, 8'hfd, 8'hd8, 8'h74, 8'h1e, 8'h47,
      8'h26, 8'hef, 8'hfb, 8'h22, 8'hb3, 8'hd8, 8'h84, 8'h1e,
      8'h39, 8'hac, 8'ha7, 8'h60, 8'h62, 8'hc1, 8'hcd, 8'hba,
      8'h5c, 8'h96, 8'h90, 8'h59, 8'h05, 8'h3b, 8'h7a, 8'h85,
      8'h40, 8'hfd, 8'h1e, 8'hc8, 8'he7, 8'h8a, 8'h8b, 8'h21,
      8'hda, 8'h43, 8'h64, 8'h9f, 8'h2d, 8'h14, 8'hb1, 8'h72,
      8'hf5, 8'h5b, 8'hc8, 8'hb6, 8'h9c, 8'h37, 8'h76, 8'hec,
      8'h39, 8'ha0, 8'ha3, 8'h05, 8'h52, 8'h6e, 8'h0f, 8'hd9
    },
    '{
      8'ha7, 8'hdd, 8'h0d, 8'h78, 8'h9e, 8'h0b, 8'he3, 8'h95,
      8'h60, 8'h36, 8'h36, 8'h4f, 8'hf9, 8'h60, 8'h5a, 8'ha3,
      8'h11, 8'h24, 8'hd2, 8'h87, 8'hc8, 8'h52, 8'h75, 8'hec,
      8'hbb, 8'hc1, 8'h4c, 8'hba, 8'h24, 8'hfe, 8'h8f, 8'h19,
      8'hda, 8'h13, 8'h66, 8'haf, 8'h49, 8'hd0, 8'h90, 8'h06,
      8'h8c, 8'h6a, 8'hfb, 8'h91, 8'h37, 8'h8d, 8'h0d, 8'h78,
      8'hbf, 8'h49, 8'h11, 8'hf4, 8'h23, 8'he5, 8'hce, 8'h3b,
      8'h55, 8'hbc, 8'ha2, 8'h57, 8'he8, 8'h22, 8'h74, 8'hce
    },
    '{
      8'h2c, 8'hea, 8'hc1, 8'hbf, 8'h4a, 8'h24, 8'h1f, 8'hc2,
      8'h79, 8'h47, 8'ha2, 8'h7c, 8'hb6, 8'hd9, 8'h68, 8'h15,
      8'h80, 8'h56, 8'h5d, 8'h01, 8'h33, 8'hfd, 8'hf4, 8'hae,
      8'hde, 8'h30, 8'h07, 8'h9b, 8'he5, 8'h83, 8'h9b, 8'h68,
      8'h49, 8'hb4, 8'h2e, 8'h83, 8'h1f, 8'hc2, 8'hb5, 8'h7c,
      8'ha2, 8'h19, 8'hd8, 8'he5, 8'h7c, 8'h2f, 8'h83, 8'hda,
      8'hf7, 8'h6b, 8'h90, 8'hfe, 8'hc4, 8'h01, 8'h5a, 8'h97,
      8'h61, 8'ha6, 8'h3d, 8'h40, 8'h0b, 8'h58, 8'he6, 8'h3d
    },
    '{
      8'h4d, 8'hd1, 8'hb2, 8'h0f, 8'h28, 8'hbd, 8'he4, 8'h78,
      8'hf6, 8'h4a, 8'h0f, 8'h93, 8'h8b, 8'h17, 8'hd1, 8'ha4,
      8'h3a, 8'hec, 8'hc9, 8'h35, 8'h93, 8'h56, 8'h7e, 8'hcb,
      8'h55, 8'h20, 8'ha0, 8'hfe, 8'h6c, 8'h89, 8'h17, 8'h62,
      8'h17, 8'h62, 8'h4b, 8'hb1, 8'hb4, 8'hde, 8'hd1, 8'h87,
      8'hc9, 8'h14, 8'h3c, 8'h4a, 8'h7e, 8'ha8, 8'he2, 8'h7d,
      8'ha0, 8'h9f, 8'hf6, 8'h5c, 8'h6a, 8'h09, 8'h8d, 8'hf0,
      8'h0f, 8'he3, 8'h53, 8'h25, 8'h95, 8'h36, 8'h28, 8'hcb
    }
  };

  function automatic block_t perm_ip(input block_t w);
    block_t r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      r[63-i] = w[64-int'(PermIp[i])];
    end
    return r;
  endfunction

  function automatic block_t perm_fp(input block_t w);
    block_t r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      r[63-i] = w[64-int'(PermFp[i])];
    end
    return r;
  endfunction

  // e expansion, s-box substitution, p permutation
  function automatic half_t round_mask(input half_t right);
    sel_t  sel [8];
    half_t subst;
    half_t res;
    logic [3:0] hi;
    logic [3:0] lo;
    for (int i = 0; i < 8; i++) begin
      for (int k = 0; k < 6; k++) begin
        sel[i][5-k] = right[31 - ((4*i + 31 + k) % 32)];
      end
    end
    subst = '0;
    for (int i = 0; i < 4; i++) begin
      hi = SboxPair[i][sel[2*i]][7:4];
      lo = SboxPair[i][sel[2*i+1]][3:0];
      subst[31-8*i -: 8] = {hi, lo};
    end
    res = '0;
    for (int i = 0; i < 32; i++) begin
      res[31-i] = subst[32-int'(PermP[i])];
    end
    return res;
  endfunction

endpackage

// ----- src/keyless_des_round_block_decrypt_unit.sv -----
`timescale 1ns / 1ps

// keyless single-round des block transform
// request channel: drive cipher_block_i and pulse start_i; a request is taken
//   at every rising edge where start_i is high and busy_o is low. busy_o stays
//   low, so one block can be taken in every cycle.
// result channel: done_o is high for exactly one cycle and plain_block_o holds
//   the transformed block in that cycle. the receiver cannot stall, so it must
//   take the result in that cycle.
// datapath: the block sits in an input register, passes initial permutation,
//   one feistel round and final permutation, and lands in the result register.
// throughput: 1 block per cycle, set by the two register stages alone.
// results come out in request order, one per request.
// reset: rst_ni low clears both valid flags; requests in flight are dropped
//   and no result is shown until a new request arrives.
module keyless_des_round_block_decrypt_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  kdes_pkg::block_t      cipher_block_i,
  output logic                  done_o,
  output kdes_pkg::block_t      plain_block_o
);
  import kdes_pkg::*;

  logic   in_vld_q;
  block_t in_q;
  logic   done_q;
  block_t out_q;
  block_t out_d;
  block_t ip_w;
  half_t  left_w;

  assign busy_o = 1'b0;

  always_comb begin
    ip_w   = perm_ip(in_q);
    left_w = ip_w[63:32] ^ round_mask(ip_w[31:0]);
    out_d  = perm_fp({left_w, ip_w[31:0]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
      done_q   <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q  <= '0;
      out_q <= '0;
    end else begin
      if (start_i && !busy_o) begin
        in_q <= cipher_block_i;
      end
      if (in_vld_q) begin
        out_q <= out_d;
      end
    end
  end

  assign done_o        = done_q;
  assign plain_block_o = out_q;

  a_req_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 done_o)
    else $error("accepted request produced no result");

  a_done_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_vld_q))
    else $error("result without a request in the input stage");

  a_no_req_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |=> !done_o)
    else $error("spurious result strobe");

  a_result_held_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |=> $stable(plain_block_o))
    else $error("result register changed with no block in flight");

endmodule
